// ===== sv/erot_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erot_pkg
// Shared types, constants and tables of the Euler point rotator.
// ----------------------------------------------------------------------------
package erot_pkg;

	localparam int ENTRY_W  = 18;
	localparam int CRD_W    = 34;
	localparam int PROD_W   = 68;
	localparam int ATAN_LEN = 24;
	localparam int MPROG_LEN = 16;

	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_BETA  = 2'd1;
	localparam logic [1:0] REG_GAMMA = 2'd2;

	localparam logic signed [CRD_W-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [CRD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [CRD_W-1:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [CRD_W-1:0] ONE_Q30     = 34'sd1073741824;

	localparam logic signed [ENTRY_W-1:0] ENTRY_ONE = 18'sd65536;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 18'sd131071;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = -18'sd131072;

	typedef logic [8:0][ENTRY_W-1:0] matrix_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_LOAD,
		B_ROT,
		B_MSTART,
		B_MUL,
		B_POST
	} bld_state_t;

	typedef enum logic [2:0] {
		OP_S1,
		OP_S2,
		OP_S3,
		OP_C1,
		OP_C2,
		OP_C3,
		OP_ONE,
		OP_TMP
	} opnd_t;

	typedef struct packed {
		opnd_t a;
		opnd_t b;
		logic  neg;
		logic  first;
		logic  to_tmp;
		logic  last;
	} mop_t;

	typedef struct packed {
		logic ready;
		logic busy;
	} mat_status_t;

	function automatic logic signed [CRD_W-1:0] atan_q30(input logic [4:0] i);
		logic signed [CRD_W-1:0] r;
		case (i)
			5'd0:  r = 34'sd843314857;
			5'd1:  r = 34'sd497837829;
			5'd2:  r = 34'sd263043837;
			5'd3:  r = 34'sd133525159;
			5'd4:  r = 34'sd67021687;
			5'd5:  r = 34'sd33543516;
			5'd6:  r = 34'sd16775851;
			5'd7:  r = 34'sd8388437;
			5'd8:  r = 34'sd4194283;
			5'd9:  r = 34'sd2097149;
			5'd10: r = 34'sd1048576;
			5'd11: r = 34'sd524288;
			5'd12: r = 34'sd262144;
			5'd13: r = 34'sd131072;
			5'd14: r = 34'sd65536;
			5'd15: r = 34'sd32768;
			5'd16: r = 34'sd16384;
			5'd17: r = 34'sd8192;
			5'd18: r = 34'sd4096;
			5'd19: r = 34'sd2048;
			5'd20: r = 34'sd1024;
			5'd21: r = 34'sd512;
			5'd22: r = 34'sd256;
			5'd23: r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

	// product program: entries built row-major, tmp holds a Q30 rounded pair
	function automatic mop_t mprog(input logic [3:0] pc);
		mop_t m;
		case (pc)
			4'd0:  m = '{OP_C2,  OP_C3, 1'b0, 1'b1, 1'b0, 1'b1};
			4'd1:  m = '{OP_C2,  OP_S3, 1'b1, 1'b1, 1'b0, 1'b1};
			4'd2:  m = '{OP_S2,  OP_ONE, 1'b0, 1'b1, 1'b0, 1'b1};
			4'd3:  m = '{OP_S1,  OP_S2, 1'b0, 1'b0, 1'b1, 1'b0};
			4'd4:  m = '{OP_TMP, OP_C3, 1'b0, 1'b1, 1'b0, 1'b0};
			4'd5:  m = '{OP_S3,  OP_C1, 1'b0, 1'b0, 1'b0, 1'b1};
			4'd6:  m = '{OP_C1,  OP_C3, 1'b0, 1'b1, 1'b0, 1'b0};
			4'd7:  m = '{OP_TMP, OP_S3, 1'b1, 1'b0, 1'b0, 1'b1};
			4'd8:  m = '{OP_S1,  OP_C2, 1'b1, 1'b1, 1'b0, 1'b1};
			4'd9:  m = '{OP_S1,  OP_S3, 1'b0, 1'b1, 1'b0, 1'b0};
			4'd10: m = '{OP_S2,  OP_C1, 1'b0, 1'b0, 1'b1, 1'b0};
			4'd11: m = '{OP_TMP, OP_C3, 1'b1, 1'b0, 1'b0, 1'b1};
			4'd12: m = '{OP_S2,  OP_S3, 1'b0, 1'b0, 1'b1, 1'b0};
			4'd13: m = '{OP_TMP, OP_C1, 1'b0, 1'b1, 1'b0, 1'b0};
			4'd14: m = '{OP_C3,  OP_S1, 1'b0, 1'b0, 1'b0, 1'b1};
			4'd15: m = '{OP_C1,  OP_C2, 1'b0, 1'b1, 1'b0, 1'b1};
			default: m = '{OP_ONE, OP_ONE, 1'b0, 1'b1, 1'b0, 1'b1};
		endcase
		return m;
	endfunction

endpackage

// ===== sv/erot_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erot_if
// Point request channel and rotated point result channel.
// ----------------------------------------------------------------------------
interface erot_pt_if #(parameter int COORD_BITS = 32);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic signed [COORD_BITS-1:0] coord_z;
	logic                         last_point;

	modport source (output valid, coord_x, coord_y, coord_z, last_point, input ready);
	modport sink   (input valid, coord_x, coord_y, coord_z, last_point, output ready);
endinterface

interface erot_rot_if #(parameter int COORD_BITS = 32);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] rot_x;
	logic signed [COORD_BITS-1:0] rot_y;
	logic signed [COORD_BITS-1:0] rot_z;
	logic                         last_out;

	modport source (output valid, rot_x, rot_y, rot_z, last_out, input ready);
	modport sink   (input valid, rot_x, rot_y, rot_z, last_out, output ready);
endinterface

// ===== sv/erot_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erot_fifo
// Front queue: takes point requests and holds them for the back end.
// ----------------------------------------------------------------------------
module erot_fifo #(
	parameter int WIDTH = 97,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] rdata
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (do_pop)
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wdata;
	end
endmodule

// ===== sv/erot_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erot_matrix
// Rebuilds the rotation matrix after reset or any register write: a shared
// CORDIC for the three angles, then a shift-add multiplier program.
// ----------------------------------------------------------------------------
module erot_matrix import erot_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_hit,
	input  logic [15:0]      alpha,
	input  logic [15:0]      beta,
	input  logic [15:0]      gamma,
	output matrix_t          entries,
	output mat_status_t      status
);
	localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

	bld_state_t state_q, state_d;

	logic                    stale_q;
	logic [1:0]              ang_q;
	logic [4:0]              step_q;
	logic signed [CRD_W-1:0] cx_q, cy_q, cz_q;
	logic                    flip_q;
	logic signed [CRD_W-1:0] sn_q [3];
	logic signed [CRD_W-1:0] cs_q [3];
	logic [3:0]              pc_q;
	logic [3:0]              ent_q;
	logic [5:0]              bit_q;
	logic [PROD_W-1:0]       mc_q, p_q;
	logic [CRD_W-1:0]        mp_q;
	logic                    psign_q;
	logic signed [CRD_W-1:0] tmp_q;
	logic signed [PROD_W-1:0] acc_q;
	matrix_t                 ent_mat_q;

	logic [15:0]              ang_sel;
	logic signed [CRD_W-1:0]  z0, xs, ys, at;
	logic                     rot_done;
	mop_t                     mop;
	logic signed [CRD_W-1:0]  opa, opb;
	logic signed [PROD_W-1:0] prod, acc_n, rnd44;
	logic signed [23:0]       ent_r;
	logic signed [ENTRY_W-1:0] ent_c;

	function automatic logic signed [CRD_W-1:0] pick(input opnd_t s,
		input logic signed [CRD_W-1:0] s1, input logic signed [CRD_W-1:0] s2,
		input logic signed [CRD_W-1:0] s3, input logic signed [CRD_W-1:0] c1,
		input logic signed [CRD_W-1:0] c2, input logic signed [CRD_W-1:0] c3,
		input logic signed [CRD_W-1:0] t);
		logic signed [CRD_W-1:0] r;
		case (s)
			OP_S1:   r = s1;
			OP_S2:   r = s2;
			OP_S3:   r = s3;
			OP_C1:   r = c1;
			OP_C2:   r = c2;
			OP_C3:   r = c3;
			OP_ONE:  r = ONE_Q30;
			OP_TMP:  r = t;
			default: r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		case (ang_q)
			REG_ALPHA: ang_sel = alpha;
			REG_BETA:  ang_sel = beta;
			REG_GAMMA: ang_sel = gamma;
			default:   ang_sel = gamma;
		endcase
	end

	assign z0       = {ang_sel[15], ang_sel, 17'b0};
	assign xs       = cx_q >>> step_q;
	assign ys       = cy_q >>> step_q;
	assign at       = atan_q30(step_q);
	assign rot_done = (step_q == 5'(NSTEP-1));

	assign mop   = mprog(pc_q);
	assign opa   = pick(mop.a, sn_q[0], sn_q[1], sn_q[2], cs_q[0], cs_q[1], cs_q[2], tmp_q);
	assign opb   = pick(mop.b, sn_q[0], sn_q[1], sn_q[2], cs_q[0], cs_q[1], cs_q[2], tmp_q);
	assign prod  = psign_q ? -$signed(p_q) : $signed(p_q);
	assign acc_n = mop.first ? prod : acc_q + prod;
	assign rnd44 = (acc_n + (PROD_W'(1) <<< 43)) >>> 44;
	assign ent_r = rnd44[23:0];
	assign ent_c = (ent_r > 24'(ENTRY_MAX)) ? ENTRY_MAX :
		(ent_r < 24'(ENTRY_MIN)) ? ENTRY_MIN : ent_r[ENTRY_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:   if (stale_q) state_d = B_LOAD;
			B_LOAD:   state_d = B_ROT;
			B_ROT:    if (rot_done) state_d = (ang_q == REG_GAMMA) ? B_MSTART : B_LOAD;
			B_MSTART: state_d = B_MUL;
			B_MUL:    if (bit_q == 6'(CRD_W-1)) state_d = B_POST;
			B_POST:   state_d = (pc_q == 4'(MPROG_LEN-1)) ? B_IDLE : B_MSTART;
			default:  state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		status.busy  = (state_q != B_IDLE);
		status.ready = (state_q == B_IDLE) && !stale_q;
		entries      = ent_mat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			stale_q <= 1'b1;
			ang_q   <= '0;
			pc_q    <= '0;
			ent_q   <= '0;
			ent_mat_q <= '{ENTRY_ONE, '0, '0, '0, ENTRY_ONE, '0, '0, '0, ENTRY_ONE};
		end else begin
			state_q <= state_d;
			if (cfg_hit)
				stale_q <= 1'b1;
			else if (state_q == B_IDLE)
				stale_q <= 1'b0;
			if (state_q == B_IDLE) begin
				ang_q <= '0;
				pc_q  <= '0;
				ent_q <= '0;
			end
			if (state_q == B_ROT && rot_done && ang_q != REG_GAMMA)
				ang_q <= ang_q + 1'b1;
			if (state_q == B_POST) begin
				pc_q <= pc_q + 1'b1;
				if (!mop.to_tmp && mop.last) begin
					ent_mat_q[ent_q] <= ent_c;
					ent_q <= ent_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_LOAD: begin
				cx_q   <= GAIN_Q30;
				cy_q   <= '0;
				step_q <= '0;
				if (z0 > HALF_PI_Q30) begin
					cz_q   <= z0 - PI_Q30;
					flip_q <= 1'b1;
				end else if (z0 < -HALF_PI_Q30) begin
					cz_q   <= z0 + PI_Q30;
					flip_q <= 1'b1;
				end else begin
					cz_q   <= z0;
					flip_q <= 1'b0;
				end
			end
			B_ROT: begin
				step_q <= step_q + 1'b1;
				if (!cz_q[CRD_W-1]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end
				if (rot_done) begin
					cs_q[ang_q] <= flip_q ? -(cx_q + (cz_q[CRD_W-1] ? ys : -ys)) :
						(cx_q + (cz_q[CRD_W-1] ? ys : -ys));
					sn_q[ang_q] <= flip_q ? -(cy_q + (cz_q[CRD_W-1] ? -xs : xs)) :
						(cy_q + (cz_q[CRD_W-1] ? -xs : xs));
				end
			end
			B_MSTART: begin
				mc_q    <= PROD_W'(opa[CRD_W-1] ? -opa : opa);
				mp_q    <= opb[CRD_W-1] ? CRD_W'(-opb) : CRD_W'(opb);
				psign_q <= opa[CRD_W-1] ^ opb[CRD_W-1] ^ mop.neg;
				p_q     <= '0;
				bit_q   <= '0;
			end
			B_MUL: begin
				if (mp_q[0])
					p_q <= p_q + mc_q;
				mc_q  <= mc_q << 1;
				mp_q  <= mp_q >> 1;
				bit_q <= bit_q + 1'b1;
			end
			B_POST: begin
				if (mop.to_tmp)
					tmp_q <= CRD_W'((prod + (PROD_W'(1) <<< 29)) >>> 30);
				else
					acc_q <= acc_n;
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== sv/erot_dot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erot_dot
// Back end: three-stage matrix-vector pipeline with rounding and saturation.
// ----------------------------------------------------------------------------
module erot_dot import erot_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  matrix_t                      mat,
	input  logic                         in_valid,
	input  logic [3*COORD_BITS:0]        in_data,
	output logic                         advance,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic signed [COORD_BITS-1:0] out_z,
	output logic                         out_last
);
	localparam int CB = COORD_BITS;
	localparam int HW = CB - 15;
	localparam int PH = ENTRY_W + HW;
	localparam int SW = PH + 2;
	localparam int VW = ((SW > 21) ? SW : 21) + 1;
	localparam logic signed [VW-1:0] CMAX = {{(VW-CB+1){1'b0}}, {(CB-1){1'b1}}};
	localparam logic signed [VW-1:0] CMIN = ~CMAX;

	logic signed [CB-1:0] cin [3];
	logic signed [HW-1:0] hi [3];
	logic signed [16:0]   lo [3];

	logic                 v_s1, v_s2, v_s3;
	logic signed [PH-1:0] ph_s1 [9];
	logic signed [34:0]   pl_s1 [9];
	logic                 last_s1, last_s2;
	logic signed [SW-1:0] sh_s2 [3];
	logic signed [20:0]   slr_s2 [3];
	logic signed [CB-1:0] rot_s3 [3];
	logic                 last_s3;

	assign advance = !v_s3 || out_ready;
	assign cin[0]  = in_data[3*CB:2*CB+1];
	assign cin[1]  = in_data[2*CB:CB+1];
	assign cin[2]  = in_data[CB:1];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			hi[k] = HW'(cin[k] >>> 16);
			lo[k] = {1'b0, cin[k][15:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					ph_s1[r*3+k] <= $signed(mat[r*3+k]) * hi[k];
					pl_s1[r*3+k] <= $signed(mat[r*3+k]) * lo[k];
				end
			end
			last_s1 <= in_data[0];
			for (int r = 0; r < 3; r++) begin
				sh_s2[r]  <= SW'(ph_s1[r*3]) + SW'(ph_s1[r*3+1]) + SW'(ph_s1[r*3+2]);
				slr_s2[r] <= 21'((37'(pl_s1[r*3]) + 37'(pl_s1[r*3+1]) + 37'(pl_s1[r*3+2])
					+ 37'sd32768) >>> 16);
			end
			last_s2 <= last_s1;
			for (int r = 0; r < 3; r++) begin
				if (VW'(sh_s2[r]) + VW'(slr_s2[r]) > CMAX)
					rot_s3[r] <= CMAX[CB-1:0];
				else if (VW'(sh_s2[r]) + VW'(slr_s2[r]) < CMIN)
					rot_s3[r] <= CMIN[CB-1:0];
				else
					rot_s3[r] <= CB'(VW'(sh_s2[r]) + VW'(slr_s2[r]));
			end
			last_s3 <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_x     = rot_s3[0];
	assign out_y     = rot_s3[1];
	assign out_z     = rot_s3[2];
	assign out_last  = last_s3;
endmodule

// ===== sv/euler_point_rotator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_point_rotator
// Rotates Q16.16 points by the matrix of three Euler angles (x, y, z order).
// ----------------------------------------------------------------------------
// Channels: pts takes point requests (coord_x/y/z, last_point), rots returns
// one rotated point per request with last_out copied, both valid/ready.
// Angles are written on cfg_we/cfg_index/cfg_data (0 alpha, 1 beta, 2 gamma,
// Q3.13 radians); other indexes are ignored. Write only while no point is
// in flight.
// Matrix build: after reset and after each register write the matrix is
// rebuilt by the CORDIC iterations and a bit-serial 34x34 multiplier
// program; points queue meanwhile and are held back.
// Points: one per cycle unless stalled or held by a matrix build; a taken
// request passes the queue, product stage, sum stage and output register.
// Reset clears the queue and pipeline and starts a matrix build at angle 0.
// When the receiver stalls the pipeline holds and the 4-entry front queue
// keeps taking requests until full.
// ----------------------------------------------------------------------------
module euler_point_rotator import erot_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int COORD_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	erot_pt_if.sink     pts,
	erot_rot_if.source  rots
);
	localparam int PW = 3*COORD_BITS + 1;

	logic [15:0]   alpha_q, beta_q, gamma_q;
	logic          cfg_hit;
	matrix_t       mat;
	mat_status_t   mstat;
	logic          q_full, q_nonempty, q_pop, advance;
	logic [PW-1:0] q_rdata;

	assign cfg_hit = cfg_we && (cfg_index == REG_ALPHA || cfg_index == REG_BETA ||
		cfg_index == REG_GAMMA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			beta_q  <= '0;
			gamma_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data;
				REG_BETA:  beta_q  <= cfg_data;
				REG_GAMMA: gamma_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	erot_fifo #(.WIDTH(PW), .DEPTH(4)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (pts.valid),
		.wdata    ({pts.coord_x, pts.coord_y, pts.coord_z, pts.last_point}),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	assign pts.ready = !q_full;
	assign q_pop     = advance && mstat.ready && !cfg_hit;

	erot_matrix #(.CORDIC_STEPS(CORDIC_STEPS)) u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_hit (cfg_hit),
		.alpha   (alpha_q),
		.beta    (beta_q),
		.gamma   (gamma_q),
		.entries (mat),
		.status  (mstat)
	);

	erot_dot #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat       (mat),
		.in_valid  (q_pop && q_nonempty),
		.in_data   (q_rdata),
		.advance   (advance),
		.out_valid (rots.valid),
		.out_ready (rots.ready),
		.out_x     (rots.rot_x),
		.out_y     (rots.rot_y),
		.out_z     (rots.rot_z),
		.out_last  (rots.last_out)
	);
endmodule

// ===== sv/erot_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erot_checker
// Port-level checks of the Euler point rotator, bound to the top level.
// ----------------------------------------------------------------------------
module erot_checker #(
	parameter int COORD_BITS = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] out_x,
	input logic [COORD_BITS-1:0] out_y,
	input logic [COORD_BITS-1:0] out_z,
	input logic                  out_last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) &&
		$stable(out_z) && $stable(out_last))
		else $error("stalled result changed");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("queue filled without a request");

	a_reset_quiet: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result right after reset");
endmodule

bind euler_point_rotator erot_checker #(.COORD_BITS(COORD_BITS)) u_erot_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pts.valid),
	.in_ready  (pts.ready),
	.out_valid (rots.valid),
	.out_ready (rots.ready),
	.out_x     (rots.rot_x),
	.out_y     (rots.rot_y),
	.out_z     (rots.rot_z),
	.out_last  (rots.last_out)
);
